// ===== design/frr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_pkg
// Shared types, codes and constants for the framed reply receiver.
// ----------------------------------------------------------------------------
package frr_pkg;

  localparam int QDEPTH = 4;

  localparam logic [7:0] CH_HEADER = 8'h70;
  localparam logic [7:0] CH_BEAT   = 8'h68;
  localparam logic [7:0] CH_MSG    = 8'h6d;

  localparam logic [2:0] BEAT_LAST = 3'd5;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LENGTH = 3'd1,
    PH_TYPE   = 3'd2,
    PH_WORD   = 3'd3,
    PH_SKIP   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BEAT = 2'd0,
    KIND_MSG  = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_UNK  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
  } cmd_t;

  function automatic logic [7:0] beat_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = CH_HEADER;
      3'd1:    b = 8'h01;
      3'd5:    b = CH_BEAT;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== design/frr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_front
// Frame parser: takes one byte per request and posts reply commands.
// ----------------------------------------------------------------------------
module frr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    rx_byte,
  output logic          push,
  output frr_pkg::cmd_t push_cmd
);

  frr_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]     len_r, len_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic [31:0]     val_r, val_nxt;
  logic            halted_r, halted_nxt;
  logic [31:0]     len_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= frr_pkg::PH_HEADER;
      len_r    <= '0;
      idx_r    <= '0;
      val_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      val_r    <= val_nxt;
      halted_r <= halted_nxt;
    end
  end

  assign len_dec = len_r - 32'd1;

  always_comb begin
    phase_nxt      = phase_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    halted_nxt     = halted_r;
    push           = 1'b0;
    push_cmd.kind  = frr_pkg::KIND_MSG;
    push_cmd.value = '0;
    if (acc && !halted_r) begin
      unique case (phase_r)
        frr_pkg::PH_LENGTH: begin
          len_nxt[8*idx_r +: 8] = len_r[8*idx_r +: 8] | rx_byte;
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            phase_nxt = frr_pkg::PH_TYPE;
          end
        end
        frr_pkg::PH_TYPE: begin
          phase_nxt = frr_pkg::PH_HEADER;
          if (rx_byte == frr_pkg::CH_BEAT) begin
            push          = 1'b1;
            push_cmd.kind = frr_pkg::KIND_BEAT;
          end else if (rx_byte == frr_pkg::CH_MSG) begin
            val_nxt = '0;
            idx_nxt = '0;
            if (len_r == 32'd0) begin
              push          = 1'b1;
              push_cmd.kind = frr_pkg::KIND_MSG;
            end else begin
              phase_nxt = frr_pkg::PH_WORD;
            end
          end else begin
            push          = 1'b1;
            push_cmd.kind = frr_pkg::KIND_UNK;
          end
        end
        frr_pkg::PH_WORD, frr_pkg::PH_SKIP: begin
          if (phase_r == frr_pkg::PH_WORD) begin
            val_nxt[8*idx_r +: 8] = val_r[8*idx_r +: 8] | rx_byte;
            idx_nxt = idx_r + 2'd1;
            if (idx_r == 2'd3) begin
              phase_nxt = frr_pkg::PH_SKIP;
            end
          end
          len_nxt = len_dec;
          if (len_dec == 32'd0) begin
            push           = 1'b1;
            push_cmd.kind  = frr_pkg::KIND_MSG;
            push_cmd.value = val_nxt;
            phase_nxt      = frr_pkg::PH_HEADER;
            idx_nxt        = '0;
          end
        end
        default: begin
          if (rx_byte == frr_pkg::CH_HEADER) begin
            phase_nxt = frr_pkg::PH_LENGTH;
            len_nxt   = '0;
            idx_nxt   = '0;
          end else begin
            push          = 1'b1;
            push_cmd.kind = frr_pkg::KIND_BAD;
            halted_nxt    = 1'b1;
            phase_nxt     = frr_pkg::PH_HEADER;
          end
        end
      endcase
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r && !push)
    else $error("frr_front: halt released or command posted while halted");

endmodule

// ===== design/frr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_queue
// Short command queue between the frame parser and the reply sequencer.
// ----------------------------------------------------------------------------
module frr_queue #(
  parameter int DEPTH = frr_pkg::QDEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  frr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output frr_pkg::cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  frr_pkg::cmd_t   mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("frr_queue: command pushed into full queue");

endmodule

// ===== design/frr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_back
// Reply sequencer: expands queued commands into result requests.
// ----------------------------------------------------------------------------
module frr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  frr_pkg::cmd_t       q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_result_kind,
  output logic [7:0]          out_tx_byte,
  output logic signed [31:0]  out_calc_value,
  output logic                out_last
);

  logic        valid_r, valid_nxt;
  logic [2:0]  beat_r, beat_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  tx_r, tx_nxt;
  logic [31:0] val_r, val_nxt;
  logic        last_r, last_nxt;
  logic        load;

  assign load = q_valid && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    beat_nxt  = beat_r;
    kind_nxt  = kind_r;
    tx_nxt    = tx_r;
    val_nxt   = val_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      kind_nxt  = q_head.kind;
      if (q_head.kind == frr_pkg::KIND_BEAT) begin
        tx_nxt   = frr_pkg::beat_byte(beat_r);
        val_nxt  = '0;
        last_nxt = (beat_r == frr_pkg::BEAT_LAST);
        if (beat_r == frr_pkg::BEAT_LAST) begin
          beat_nxt = '0;
          q_pop    = 1'b1;
        end else begin
          beat_nxt = beat_r + 3'd1;
        end
      end else begin
        tx_nxt   = '0;
        val_nxt  = q_head.value;
        last_nxt = 1'b1;
        q_pop    = 1'b1;
      end
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      beat_r  <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    tx_r   <= tx_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_result_kind = kind_r;
  assign out_tx_byte     = tx_r;
  assign out_calc_value  = signed'(val_r);
  assign out_last        = last_r;

  a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
    beat_r <= frr_pkg::BEAT_LAST)
    else $error("frr_back: heartbeat counter out of range");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r != frr_pkg::KIND_BEAT |-> last_r)
    else $error("frr_back: single result without last");

endmodule

// ===== design/framed_reply_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_reply_receiver
// Length-prefixed frame receiver with heartbeat reply.
//
// Input channel (in_valid / in_stall / in_rx_byte) takes one link byte per
// request. Frames are 'p', a 4-byte little-endian length and a type byte.
// Output channel (out_valid / out_stall / out_*) gives one result per
// request: six heartbeat reply bytes, one message word, or an error code;
// out_last marks the final result caused by one input byte.
// A result reaches the output from the byte that causes it through the
// command queue and then the output register.
// Throughput: one byte per cycle unless in_stall is high; a heartbeat drains
// six results through the sequencer at one per cycle unless out_stall is high.
// A command queue of QUEUE_DEPTH entries sits between parser and sequencer;
// in_stall rises only while that queue is full.
// A wrong header byte halts parsing: later bytes are taken and dropped.
// Reset (rst_n low, synchronous) empties the queue and clears the halt.
// While out_stall is high a valid output holds and the queue can fill.
// ----------------------------------------------------------------------------
module framed_reply_receiver #(
  parameter int QUEUE_DEPTH = frr_pkg::QDEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_result_kind,
  output logic [7:0]         out_tx_byte,
  output logic signed [31:0] out_calc_value,
  output logic               out_last
);

  logic          q_full, q_valid, q_pop, push;
  frr_pkg::cmd_t push_cmd, q_head;

  assign in_stall = q_full;

  frr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_valid && !in_stall),
    .rx_byte  (in_rx_byte),
    .push     (push),
    .push_cmd (push_cmd)
  );

  frr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  frr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_tx_byte     (out_tx_byte),
    .out_calc_value  (out_calc_value),
    .out_last        (out_last)
  );

endmodule
